// ===== design/matrix_integer_power_unit_macros.svh =====
// Assertion macros shared by the matrix integer power unit.
// Stand-alone header; no other file is needed.
`ifndef MATRIX_INTEGER_POWER_UNIT_MACROS_SVH
`define MATRIX_INTEGER_POWER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MIP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mip assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mip assertion failed");

`endif

// ===== design/mip_pkg.sv =====
// Shared types and constants of the matrix integer power unit.
// No dependencies.
package mip_pkg;

   // Field widths fixed by the interface.
   localparam int ELEM_W     = 32;
   localparam int SIZE_W     = 4;
   localparam int POW_W      = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_BIT = 2;

   // Default largest matrix dimension.
   localparam int DEFAULT_MAX_DIM = 8;

   // Q16.16 arithmetic constants.
   localparam int FRAC_W     = 16;
   localparam int ROUND_HALF = 32768;
   localparam logic [ELEM_W-1:0] Q_ONE = 32'h0001_0000;

   // Register indexes on the configuration port.
   localparam logic REG_SIZE  = 1'b0;
   localparam logic REG_POWER = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_IDENT,
      ST_MUL,
      ST_DRAIN,
      ST_OUT_RD,
      ST_OUT_CAP,
      ST_OUT_WAIT
   } state_type;

   // Control flags that travel down the cell chain with each word.
   typedef struct packed {
      logic valid;
      logic first;
      logic lastk;
   } link_ctl_type;

endpackage

// ===== design/mip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mip_cell.sv =====
// One multiply-accumulate cell of the product chain: holds one column of the base matrix.
// Depends on mip_pkg.
module mip_cell import mip_pkg::*; #(
   parameter int MAX_DIM = DEFAULT_MAX_DIM,
   parameter int IDX     = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  link_ctl_type                           ctl_in,
   input  logic [(MAX_DIM>1?$clog2(MAX_DIM):1)-1:0] k_in,
   input  logic [(MAX_DIM*MAX_DIM>1?$clog2(MAX_DIM*MAX_DIM):1)-1:0] rbase_in,
   input  logic signed [ELEM_W-1:0]               data_in,
   output link_ctl_type                           ctl_out,
   output logic [(MAX_DIM>1?$clog2(MAX_DIM):1)-1:0] k_out,
   output logic [(MAX_DIM*MAX_DIM>1?$clog2(MAX_DIM*MAX_DIM):1)-1:0] rbase_out,
   output logic signed [ELEM_W-1:0]               data_out,
   input  logic                                   ld_valid,
   input  logic [(MAX_DIM>1?$clog2(MAX_DIM):1)-1:0] ld_row,
   input  logic [(MAX_DIM>1?$clog2(MAX_DIM):1)-1:0] ld_col,
   input  logic signed [ELEM_W-1:0]               ld_data,
   output logic                                   res_valid,
   output logic [(MAX_DIM*MAX_DIM>1?$clog2(MAX_DIM*MAX_DIM):1)-1:0] res_addr,
   output logic signed [ELEM_W-1:0]               res_data
);

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);

   logic signed [ELEM_W-1:0] col_mem_ff [MAX_DIM];

   link_ctl_type             ctl1_ff;
   logic [IDX_W-1:0]         k1_ff;
   logic [ADDR_W-1:0]        rb1_ff;
   logic signed [ELEM_W-1:0] data1_ff;

   link_ctl_type             ctl2_ff;
   logic [ADDR_W-1:0]        rb2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   logic                     done3_ff;
   logic [ADDR_W-1:0]        rb3_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   logic                     res_valid_ff;
   logic [ADDR_W-1:0]        res_addr_ff;
   logic signed [ELEM_W-1:0] res_data_ff;
   logic signed [ELEM_W-1:0] res_data_in;
   logic signed [ACC_W-1:0]  rnd_sum;
   logic signed [ACC_W-1:0]  rnd_shift;

   // Column of the base matrix, filled by the setup sweep.
   always_ff @(posedge clock) begin
      if (ld_valid && (ld_col == IDX_W'(IDX))) begin
         col_mem_ff[ld_row] <= ld_data;
      end
   end

   // Stage one: take the word from the neighbor and hand it on.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= ctl_in;
      end
      k1_ff    <= k_in;
      rb1_ff   <= rbase_in;
      data1_ff <= data_in;
   end

   // Stage two: multiply by this column's entry.
   assign prod_in = data1_ff * col_mem_ff[k1_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl1_ff;
      end
      rb2_ff  <= rb1_ff;
      prod_ff <= prod_in;
   end

   // Stage three: accumulate the exact sum of products.
   always_comb begin
      acc_in = acc_ff;
      if (ctl2_ff.valid) begin
         if (ctl2_ff.first) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done3_ff <= 1'b0;
      end else begin
         done3_ff <= ctl2_ff.valid & ctl2_ff.lastk;
      end
      rb3_ff <= rb2_ff;
      acc_ff <= acc_in;
   end

   // Stage four: round half up to Q16.16 and saturate.
   always_comb begin
      rnd_sum   = acc_ff + ACC_W'(ROUND_HALF);
      rnd_shift = rnd_sum >>> FRAC_W;
      if (rnd_shift > SAT_HI) begin
         res_data_in = ELEM_W'(SAT_HI);
      end else if (rnd_shift < SAT_LO) begin
         res_data_in = ELEM_W'(SAT_LO);
      end else begin
         res_data_in = ELEM_W'(rnd_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= done3_ff;
      end
      res_addr_ff <= ADDR_W'(rb3_ff + ADDR_W'(IDX));
      res_data_ff <= res_data_in;
   end

   assign ctl_out   = ctl1_ff;
   assign k_out     = k1_ff;
   assign rbase_out = rb1_ff;
   assign data_out  = data1_ff;
   assign res_valid = res_valid_ff;
   assign res_addr  = res_addr_ff;
   assign res_data  = res_data_ff;

endmodule

// ===== design/matrix_integer_power_unit.sv =====
// Matrix integer power unit: loads a square Q16.16 matrix word by word, raises it to
// a configured power through a chain of multiply-accumulate cells and streams the result.
// Depends on mip_pkg, mip_ram, mip_cell and matrix_integer_power_unit_macros.svh.
//
// Usage: write matrix_size (address 0) and power (address 4) over the APB port while
// idle. Then send n*n words on req_ (valid/stall), one element per word in row-major
// order; req_stall is low only while loading, so while loading every word offered on req_valid is taken.
// After the last word the running matrix is built in a RAM: power 1 keeps the matrix,
// power 0 writes the identity, and each further multiplication streams the running
// matrix down the cell chain and then drains it while the products are written back.
// The n*n result words leave on rsp_ with rsp_last on the final one, each read in turn
// through the RAM read port into the output register; a negative power gives one
// word with value zero, last and error set. A stall from the receiver holds the output
// register and the sweep waits. Reset empties the block and sets size 1 and power 1.
`include "matrix_integer_power_unit_macros.svh"

module matrix_integer_power_unit import mip_pkg::*; #(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_value,
   output logic                     rsp_last,
   output logic                     rsp_error,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int DRAIN_LEN = MAX_DIM + 8;
   localparam int DRN_W     = $clog2(DRAIN_LEN);
   localparam int REM_W     = POW_W - 1;

   // Configuration registers.
   logic [SIZE_W-1:0] size_ff;
   logic [POW_W-1:0]  power_ff;
   logic              csr_write;

   // Controller state and counters.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] rbase_ff, rbase_in;
   logic [DRN_W-1:0]  drn_ff, drn_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIM_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  cells_ff, cells_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_error_ff, rsp_error_in;

   // Derived control.
   logic [SIZE_W:0]   size_x;
   logic [DIM_W-1:0]  n_live;
   logic [CNT_W-1:0]  cells_live;
   logic [CNT_W-1:0]  load_next;
   logic              in_accept;
   logic              out_accept;
   logic              load_done;
   logic              sweep_end;
   logic              col_end;

   // RAM ports.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ELEM_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ELEM_W-1:0] ram_rdata;

   // Word entering the cell chain and setup load bus.
   link_ctl_type      lk_ctl_ff, lk_ctl_in;
   logic [IDX_W-1:0]  lk_k_ff;
   logic [ADDR_W-1:0] lk_rb_ff;
   logic              ld_valid_ff;
   logic [IDX_W-1:0]  ld_row_ff;
   logic [IDX_W-1:0]  ld_col_ff;

   // Cell chain.
   link_ctl_type             chain_ctl  [MAX_DIM+1];
   logic [IDX_W-1:0]         chain_k    [MAX_DIM+1];
   logic [ADDR_W-1:0]        chain_rb   [MAX_DIM+1];
   logic signed [ELEM_W-1:0] chain_data [MAX_DIM+1];
   logic [MAX_DIM-1:0]       cell_vld;
   logic [ADDR_W-1:0]        cell_addr [MAX_DIM];
   logic signed [ELEM_W-1:0] cell_data [MAX_DIM];
   logic                     res_we;
   logic [ADDR_W-1:0]        res_waddr;
   logic [ELEM_W-1:0]        res_wdata;

   // Configuration port: writes complete in the access cycle, reads return the register.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_W'(1);
         power_ff <= POW_W'(1);
      end else if (csr_write) begin
         if (paddr[CSR_IDX_BIT] == REG_SIZE) begin
            size_ff <= pwdata[SIZE_W-1:0];
         end else begin
            power_ff <= pwdata[POW_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[CSR_IDX_BIT] == REG_SIZE) begin
         prdata = CSR_DATA_W'(size_ff);
      end else begin
         prdata = CSR_DATA_W'(power_ff);
      end
   end

   // Dimension in use: zero counts as one, anything above the limit as the limit.
   always_comb begin
      size_x = {1'b0, size_ff};
      if (size_ff == '0) begin
         n_live = DIM_W'(1);
      end else if (size_x > (SIZE_W+1)'(MAX_DIM)) begin
         n_live = DIM_W'(MAX_DIM);
      end else begin
         n_live = DIM_W'(size_x);
      end
      cells_live = CNT_W'(CNT_W'(n_live) * CNT_W'(n_live));
   end

   assign in_accept  = req_valid & ~req_stall;
   assign out_accept = rsp_valid_ff & ~rsp_stall;
   assign load_next  = CNT_W'(load_cnt_ff + CNT_W'(1));
   assign load_done  = in_accept & (load_next >= cells_live);
   assign sweep_end  = (cnt_ff == CNT_W'(cells_ff - CNT_W'(1)));
   assign col_end    = (DIM_W'(col_ff) == DIM_W'(n_ff - DIM_W'(1)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (load_done) begin
               if (power_ff[POW_W-1]) begin
                  state_in = ST_OUT_WAIT;
               end else if (power_ff == '0) begin
                  state_in = ST_IDENT;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (sweep_end) begin
               state_in = (rem_ff == '0) ? ST_OUT_RD : ST_MUL;
            end
         end
         ST_IDENT: begin
            if (sweep_end) begin
               state_in = ST_OUT_RD;
            end
         end
         ST_MUL: begin
            if (sweep_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drn_ff == DRN_W'(DRAIN_LEN - 1)) begin
               state_in = (rem_ff == REM_W'(1)) ? ST_OUT_RD : ST_MUL;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (out_accept) begin
               state_in = rsp_last_ff ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Counters, latched job values and the output register.
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rbase_in     = rbase_ff;
      drn_in       = drn_ff;
      rem_in       = rem_ff;
      n_in         = n_ff;
      cells_in     = cells_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (in_accept) begin
               load_cnt_in = load_next;
            end
            if (load_done) begin
               load_cnt_in = '0;
               n_in        = n_live;
               cells_in    = cells_live;
               rem_in      = REM_W'(power_ff[REM_W-1:0] - REM_W'(1));
               cnt_in      = '0;
               row_in      = '0;
               col_in      = '0;
               rbase_in    = '0;
               if (power_ff[POW_W-1]) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_error_in = 1'b1;
               end
            end
         end
         ST_SETUP, ST_IDENT, ST_MUL: begin
            cnt_in = CNT_W'(cnt_ff + CNT_W'(1));
            if (col_end) begin
               col_in   = '0;
               row_in   = IDX_W'(row_ff + IDX_W'(1));
               rbase_in = ADDR_W'(rbase_ff + ADDR_W'(n_ff));
            end else begin
               col_in = IDX_W'(col_ff + IDX_W'(1));
            end
            if (sweep_end) begin
               cnt_in   = '0;
               row_in   = '0;
               col_in   = '0;
               rbase_in = '0;
               drn_in   = '0;
            end
         end
         ST_DRAIN: begin
            drn_in = DRN_W'(drn_ff + DRN_W'(1));
            if (drn_ff == DRN_W'(DRAIN_LEN - 1)) begin
               rem_in = REM_W'(rem_ff - REM_W'(1));
            end
         end
         ST_OUT_RD: begin
         end
         ST_OUT_CAP: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = ram_rdata;
            rsp_last_in  = sweep_end;
            rsp_error_in = 1'b0;
         end
         ST_OUT_WAIT: begin
            if (out_accept) begin
               rsp_valid_in = 1'b0;
               cnt_in       = rsp_last_ff ? '0 : CNT_W'(cnt_ff + CNT_W'(1));
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs of the controller: stall, RAM ports and the word entering the chain.
   always_comb begin
      req_stall = (state_ff != ST_LOAD);
      ram_raddr = ADDR_W'(cnt_ff);
      lk_ctl_in = '0;
      if (state_ff == ST_MUL) begin
         lk_ctl_in.valid = 1'b1;
         lk_ctl_in.first = (col_ff == '0);
         lk_ctl_in.lastk = col_end;
      end
      if (state_ff == ST_LOAD) begin
         ram_we    = in_accept;
         ram_waddr = ADDR_W'(load_cnt_ff);
         ram_wdata = req_element;
      end else if (state_ff == ST_IDENT) begin
         ram_we    = 1'b1;
         ram_waddr = ADDR_W'(cnt_ff);
         ram_wdata = (row_ff == col_ff) ? Q_ONE : '0;
      end else begin
         ram_we    = res_we;
         ram_waddr = res_waddr;
         ram_wdata = res_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= '0;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rbase_ff     <= '0;
         drn_ff       <= '0;
         rem_ff       <= '0;
         n_ff         <= DIM_W'(1);
         cells_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         lk_ctl_ff    <= '0;
         ld_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rbase_ff     <= rbase_in;
         drn_ff       <= drn_in;
         rem_ff       <= rem_in;
         n_ff         <= n_in;
         cells_ff     <= cells_in;
         rsp_valid_ff <= rsp_valid_in;
         lk_ctl_ff    <= lk_ctl_in;
         ld_valid_ff  <= (state_ff == ST_SETUP);
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
      lk_k_ff      <= col_ff;
      lk_rb_ff     <= rbase_ff;
      ld_row_ff    <= row_ff;
      ld_col_ff    <= col_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_error = rsp_error_ff;

   // Running matrix; products are written back row by row in place.
   mip_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(DEPTH)
   ) u_run_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // The chain starts with the RAM read data, aligned with its registered tags.
   assign chain_ctl[0]  = lk_ctl_ff;
   assign chain_k[0]    = lk_k_ff;
   assign chain_rb[0]   = lk_rb_ff;
   assign chain_data[0] = ram_rdata;

   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      logic res_vld_raw;

      mip_cell #(
         .MAX_DIM(MAX_DIM),
         .IDX    (j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (chain_ctl[j]),
         .k_in     (chain_k[j]),
         .rbase_in (chain_rb[j]),
         .data_in  (chain_data[j]),
         .ctl_out  (chain_ctl[j+1]),
         .k_out    (chain_k[j+1]),
         .rbase_out(chain_rb[j+1]),
         .data_out (chain_data[j+1]),
         .ld_valid (ld_valid_ff),
         .ld_row   (ld_row_ff),
         .ld_col   (ld_col_ff),
         .ld_data  (ram_rdata),
         .res_valid(res_vld_raw),
         .res_addr (cell_addr[j]),
         .res_data (cell_data[j])
      );

      // Only columns inside the matrix in use write back.
      assign cell_vld[j] = res_vld_raw & (DIM_W'(j) < n_ff);
   end

   // Cells finish one after another, so at most one writes in any cycle.
   always_comb begin
      res_we    = 1'b0;
      res_waddr = cell_addr[0];
      res_wdata = cell_data[0];
      for (int j = 0; j < MAX_DIM; j++) begin
         if (cell_vld[j]) begin
            res_we    = 1'b1;
            res_waddr = cell_addr[j];
            res_wdata = cell_data[j];
         end
      end
   end

   // Checks on the controller and the chain.
   `MIP_ASSERT_NOW(a_one_writer, clock, reset, 1'b1, $onehot0(cell_vld))
   `MIP_ASSERT_NOW(a_write_in_mul, clock, reset, res_we,
      (state_ff == ST_MUL) || (state_ff == ST_DRAIN))
   `MIP_ASSERT_NOW(a_chain_end, clock, reset, chain_ctl[MAX_DIM].valid,
      (state_ff == ST_MUL) || (state_ff == ST_DRAIN))
   `MIP_ASSERT_NOW(a_error_last, clock, reset, rsp_valid_ff && rsp_error_ff,
      rsp_last_ff && (rsp_value_ff == '0))
   `MIP_ASSERT_NEXT(a_last_to_load, clock, reset, out_accept && rsp_last_ff,
      (state_ff == ST_LOAD) && !rsp_valid_ff)

endmodule
